// File: design/sfd_pkg.sv
// Package for the serial frame deframer: shared constants, the register
// index codes of the configuration port and the result record type.
// Used by the parser and the top level.
package sfd_pkg;

  // Frame geometry: two preamble bytes plus ten header bytes.
  localparam int unsigned HEADER_BYTES        = 12;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 128;
  localparam int unsigned HDR_FIELD_BYTES     = HEADER_BYTES - 2;

  // Header capture position counter and the stored part of the header.
  // The last header byte (low length byte) is used directly and not stored.
  localparam int unsigned HDR_POS_W       = $clog2(HDR_FIELD_BYTES);
  localparam int unsigned HDR_STORE_DEPTH = HDR_FIELD_BYTES - 1;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // One result word: a payload byte with the latched header fields.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic        frame_end;
    logic [7:0]  control_byte;
    logic [7:0]  spare_byte;
    logic [15:0] sequence_count;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [6:0]  frame_length;
  } sfd_result_t;

endpackage

// File: design/sfd_if.sv
// Valid/ready channel interfaces of the serial frame deframer.
// sfd_in_if carries received bytes, sfd_out_if carries payload result words.
// Depends on nothing but plain logic types.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [6:0]  payload_index;
  logic        frame_end;
  logic [7:0]  control_byte;
  logic [7:0]  spare_byte;
  logic [15:0] sequence_count;
  logic [15:0] source_address;
  logic [15:0] dest_address;
  logic [6:0]  frame_length;

  modport source (output valid, output payload_byte, output payload_index,
                  output frame_end, output control_byte, output spare_byte,
                  output sequence_count, output source_address,
                  output dest_address, output frame_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_index,
                  input frame_end, input control_byte, input spare_byte,
                  input sequence_count, input source_address,
                  input dest_address, input frame_length, output ready);
endinterface

// File: design/sfd_parser.sv
// Frame parser of the serial frame deframer: preamble hunt, header capture,
// length check and payload word generation, one byte per cycle while in_fire is high.
// Depends on sfd_pkg.
module sfd_parser #(
  parameter int unsigned PAYLOAD_CAP = sfd_pkg::MAX_FRAME_BYTES_DEF - sfd_pkg::HEADER_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                         in_fire,
  input  logic [7:0]                   in_byte,
  output logic                         res_valid,
  output sfd_pkg::sfd_result_t         res
);
  import sfd_pkg::*;

  localparam int unsigned CNT_W = $clog2(PAYLOAD_CAP + 1);
  localparam logic [15:0]      CAP_LEN = 16'(PAYLOAD_CAP);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(PAYLOAD_CAP);
  localparam logic [HDR_POS_W-1:0] HDR_POS_LAST = HDR_POS_W'(HDR_FIELD_BYTES - 1);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_HDR    = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  logic [7:0]           sync_first_r;
  logic [7:0]           sync_second_r;
  phase_t               phase_r, phase_nxt;
  logic [HDR_POS_W-1:0] hdr_pos_r, hdr_pos_nxt;
  logic [7:0]           hdr_r [HDR_STORE_DEPTH];
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W:0]       cnt_inc;
  logic [15:0]          len_field;
  logic                 hdr_last;
  logic                 hdr_we;
  logic                 last_byte;

  // Length comes from the stored high byte and the byte now arriving.
  assign len_field = {hdr_r[HDR_STORE_DEPTH-1], in_byte};
  assign hdr_last  = (hdr_pos_r == HDR_POS_LAST);
  assign cnt_inc   = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign last_byte = (cnt_inc >= {1'b0, len_r});

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    hdr_we      = 1'b0;
    res_valid   = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_SECOND: begin
          phase_nxt   = (in_byte == sync_second_r) ? PH_HDR : PH_HUNT;
          hdr_pos_nxt = '0;
        end
        PH_HDR: begin
          if (!hdr_last) begin
            hdr_we      = 1'b1;
            hdr_pos_nxt = hdr_pos_r + HDR_POS_W'(1);
          end else if (len_field <= CAP_LEN) begin
            len_nxt   = CNT_W'(len_field);
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end else begin
            // Oversized frame is dropped without any result.
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (cnt_r >= CAP_CNT) begin
            phase_nxt = PH_HUNT;
          end else begin
            res_valid = 1'b1;
            cnt_nxt   = cnt_inc[CNT_W-1:0];
            if (last_byte) begin
              phase_nxt = PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = (in_byte == sync_first_r) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  // Result word built from the arriving byte and the latched header.
  always_comb begin
    res.payload_byte   = in_byte;
    res.payload_index  = 7'(cnt_r);
    res.frame_end      = last_byte;
    res.control_byte   = hdr_r[0];
    res.spare_byte     = hdr_r[1];
    res.sequence_count = {hdr_r[2], hdr_r[3]};
    res.source_address = {hdr_r[4], hdr_r[5]};
    res.dest_address   = {hdr_r[6], hdr_r[7]};
    res.frame_length   = 7'(len_r);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[7:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Parser control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_pos_r <= '0;
      cnt_r     <= '0;
      len_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
    end
  end

  // Header byte store, written once per header position.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hdr_pos_r] <= in_byte;
    end
  end

`ifndef SYNTHESIS
  // The last payload byte always sends the parser back to the hunt.
  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_end |=> phase_r == PH_HUNT)
    else $error("parser did not return to hunt after last payload byte");

  // Header capture advances exactly one position per accepted byte.
  a_hdr_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_HDR && !hdr_last
      |=> phase_r == PH_HDR && hdr_pos_r == $past(hdr_pos_r) + HDR_POS_W'(1))
    else $error("header position did not advance");

  // While in payload, the byte count stays below the accepted length or is still zero.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (cnt_r < len_r) || (cnt_r == '0))
    else $error("payload count ran past the frame length");

  // Without an accepted byte the parser state holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r) && $stable(cnt_r) && $stable(hdr_pos_r))
    else $error("parser state moved without an accepted byte");
`endif

endmodule

// File: design/serial_frame_deframer.sv
// Top level of the serial frame deframer: parser plus a two-word output
// buffer between the byte channel and the payload channel.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and sfd_parser.
//
// Usage:
//   in_ch carries one received serial byte per word. The block hunts for the
//   two preamble bytes set in the sync_first and sync_second registers,
//   captures ten header bytes and then sends each payload byte on out_ch
//   together with the latched header fields; the last byte has frame_end set.
//   A frame whose length exceeds MAX_FRAME_BYTES minus twelve is dropped.
//   The cfg_we/cfg_index/cfg_wdata port writes the two preamble registers and
//   is to be used only while the block is idle; the block does not enforce this.
//   Throughput is one input byte per cycle while in_ch.ready is high. A payload
//   byte reaches out_ch from the output register, via the skid register while
//   out_ch stalls; bytes that produce no word leave no trace on out_ch.
//   Reset (rst_n low, synchronous) returns the parser to the preamble hunt,
//   clears both preamble registers and empties the output buffer.
//   When out_ch stalls, the output register holds its word and one more word
//   is taken into a skid register; in_ch.ready drops only while that skid
//   register is full, and it comes from a flop.
module serial_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfd_in_if.sink                         in_ch,
  sfd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfd_pkg::*;

  localparam int unsigned PAYLOAD_CAP = MAX_FRAME_BYTES - HEADER_BYTES;

  logic        in_fire;
  logic        push;
  logic        pop;
  sfd_result_t res;
  sfd_result_t out_r;
  sfd_result_t skid_r;
  logic        out_v_r;
  logic        skid_v_r;

  assign in_ch.ready = !skid_v_r;
  assign in_fire     = in_ch.valid && !skid_v_r;
  assign pop         = out_v_r && out_ch.ready;

  sfd_parser #(
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_ch.rx_byte),
    .res_valid (push),
    .res       (res)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload side of the buffer.
  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  // Drive the result channel.
  assign out_ch.valid          = out_v_r;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.payload_index  = out_r.payload_index;
  assign out_ch.frame_end      = out_r.frame_end;
  assign out_ch.control_byte   = out_r.control_byte;
  assign out_ch.spare_byte     = out_r.spare_byte;
  assign out_ch.sequence_count = out_r.sequence_count;
  assign out_ch.source_address = out_r.source_address;
  assign out_ch.dest_address   = out_r.dest_address;
  assign out_ch.frame_length   = out_r.frame_length;

`ifndef SYNTHESIS
  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held while output register is empty");

  // A new word during a stall lands in the skid register.
  a_stall_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && push |=> skid_v_r && out_v_r)
    else $error("word lost while the output was stalled");

  // Draining the output moves the skid word forward.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && pop |=> !skid_v_r && out_v_r)
    else $error("skid word not moved to the output register");
`endif

endmodule
